@@ rtl/core/box_topology_predicate_unit_macros.svh @@
// Assertion macros used by the box predicate checker.
// No dependencies; include by bare file name.
`ifndef BOX_TOPOLOGY_PREDICATE_UNIT_MACROS_SVH
`define BOX_TOPOLOGY_PREDICATE_UNIT_MACROS_SVH

// Clocked check, off while reset is asserted
`define BTP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also runs during reset
`define BTP_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/core/btp_pkg.sv @@
// Shared types and constants of the box topology predicate unit.
// No dependencies.
package btp_pkg;

  // tolerance register width
  localparam int unsigned TOL_BITS = 16;

  // predicate codes; 11 to 15 are undefined
  typedef enum logic [3:0] {
    PRED_INTERSECTS   = 4'd0,
    PRED_DISJOINT     = 4'd1,
    PRED_OVERLAP      = 4'd2,
    PRED_MEET         = 4'd3,
    PRED_INSIDE       = 4'd4,
    PRED_CONTAINS     = 4'd5,
    PRED_COVERED_BY   = 4'd6,
    PRED_COVERS       = 4'd7,
    PRED_EQUAL        = 4'd8,
    PRED_WITHIN       = 4'd9,
    PRED_CONTAINS_COV = 4'd10
  } pred_e;

  // per-stage advance enables for the compare pipeline
  typedef struct packed {
    logic s1;
    logic s2;
  } pipe_en_t;

endpackage

@@ rtl/core/btp_pair_cmp.sv @@
// Two-stage tolerance comparator for one coordinate pair (x, y).
// Depends on btp_pkg.
module btp_pair_cmp #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                             clk_i,
  input  btp_pkg::pipe_en_t                en_i,
  input  logic signed [COORD_BITS-1:0]     x_i,
  input  logic signed [COORD_BITS-1:0]     y_i,
  input  logic [btp_pkg::TOL_BITS-1:0]     tol_i,
  output logic                             gt_xy_o,  // x - y > tol
  output logic                             gt_yx_o   // y - x > tol
);

  // wide enough for the exact difference plus the tolerance
  localparam int unsigned WideBits = (COORD_BITS + 1 > btp_pkg::TOL_BITS + 1) ?
                                     COORD_BITS + 2 : btp_pkg::TOL_BITS + 2;

  logic signed [WideBits-1:0] diff_d, diff_q;
  logic signed [WideBits-1:0] tol_ext;
  logic signed [WideBits-1:0] sum_yx;
  logic                       gt_xy_q, gt_yx_q;

  // stage 1: exact difference, never wraps
  assign diff_d = WideBits'(x_i) - WideBits'(y_i);

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      diff_q <= diff_d;
    end
  end

  // stage 2: compare against +tol and -tol
  assign tol_ext = $signed({{(WideBits - btp_pkg::TOL_BITS){1'b0}}, tol_i});
  assign sum_yx  = diff_q + tol_ext;

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      gt_xy_q <= (diff_q > tol_ext);
      gt_yx_q <= sum_yx[WideBits-1];
    end
  end

  assign gt_xy_o = gt_xy_q;
  assign gt_yx_o = gt_yx_q;

endmodule

@@ rtl/core/box_topology_predicate_unit.sv @@
// Box topology predicate unit: tests two axis-aligned boxes against a chosen
// predicate with a coordinate tolerance. Takes one word per clock unless the
// input is stalled and gives one result per word from the output register.
// The work is split into a three-stage pipeline: exact corner differences,
// tolerance compares, then predicate combine into the output register. Each
// stage holds under a stall and bubbles are squeezed out. The tolerance may be
// written only while no word is in flight. Depends on btp_pkg and btp_pair_cmp.
module box_topology_predicate_unit #(
  parameter int unsigned DIMS       = 2,
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [btp_pkg::TOL_BITS-1:0]  cfg_wdata_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_BITS-1:0]  a_min_x_i,
  input  logic signed [COORD_BITS-1:0]  a_min_y_i,
  input  logic signed [COORD_BITS-1:0]  a_max_x_i,
  input  logic signed [COORD_BITS-1:0]  a_max_y_i,
  input  logic signed [COORD_BITS-1:0]  b_min_x_i,
  input  logic signed [COORD_BITS-1:0]  b_min_y_i,
  input  logic signed [COORD_BITS-1:0]  b_max_x_i,
  input  logic signed [COORD_BITS-1:0]  b_max_y_i,
  input  logic [3:0]                    req_type_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          holds_o,
  output logic                          bad_code_o
);

  logic [btp_pkg::TOL_BITS-1:0] tol_q;

  logic               v1_q, v2_q, v3_q;
  btp_pkg::pred_e     code1_q, code2_q;
  logic               holds_q, bad_q;
  logic               en3;
  btp_pkg::pipe_en_t  en;

  // corners per axis
  logic signed [COORD_BITS-1:0] a_min [DIMS];
  logic signed [COORD_BITS-1:0] a_max [DIMS];
  logic signed [COORD_BITS-1:0] b_min [DIMS];
  logic signed [COORD_BITS-1:0] b_max [DIMS];

  // tolerance compare results per axis, stage 2 outputs
  logic [DIMS-1:0] g_ab_min, g_ba_min;        // amin vs bmin
  logic [DIMS-1:0] g_ab_max, g_ba_max;        // amax vs bmax
  logic [DIMS-1:0] g_amin_bmax, g_bmax_amin;  // amin vs bmax
  logic [DIMS-1:0] g_amax_bmin, g_bmin_amax;  // amax vs bmin

  // tolerance register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // per-stage advance: a stage moves when empty or when the next one moves
  assign en3        = !v3_q || !out_stall_i;
  assign en.s2      = !v2_q || en3;
  assign en.s1      = !v1_q || en.s2;
  assign in_stall_o = !en.s1;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en.s1) v1_q <= in_valid_i;
      if (en.s2) v2_q <= v1_q;
      if (en3)   v3_q <= v2_q;
    end
  end

  // predicate code travels alongside the data
  always_ff @(posedge clk_i) begin
    if (en.s1) code1_q <= btp_pkg::pred_e'(req_type_i);
    if (en.s2) code2_q <= code1_q;
  end

  // axis mapping: x is axis 0, y is axis 1
  assign a_min[0] = a_min_x_i;
  assign a_max[0] = a_max_x_i;
  assign b_min[0] = b_min_x_i;
  assign b_max[0] = b_max_x_i;

  if (DIMS > 1) begin : g_axis_y
    assign a_min[1] = a_min_y_i;
    assign a_max[1] = a_max_y_i;
    assign b_min[1] = b_min_y_i;
    assign b_max[1] = b_max_y_i;
  end

  // four corner pairs per axis
  for (genvar d = 0; d < DIMS; d++) begin : g_axis
    btp_pair_cmp #(.COORD_BITS(COORD_BITS)) u_min_min (
      .clk_i, .en_i(en), .x_i(a_min[d]), .y_i(b_min[d]), .tol_i(tol_q),
      .gt_xy_o(g_ab_min[d]), .gt_yx_o(g_ba_min[d])
    );
    btp_pair_cmp #(.COORD_BITS(COORD_BITS)) u_max_max (
      .clk_i, .en_i(en), .x_i(a_max[d]), .y_i(b_max[d]), .tol_i(tol_q),
      .gt_xy_o(g_ab_max[d]), .gt_yx_o(g_ba_max[d])
    );
    btp_pair_cmp #(.COORD_BITS(COORD_BITS)) u_min_max (
      .clk_i, .en_i(en), .x_i(a_min[d]), .y_i(b_max[d]), .tol_i(tol_q),
      .gt_xy_o(g_amin_bmax[d]), .gt_yx_o(g_bmax_amin[d])
    );
    btp_pair_cmp #(.COORD_BITS(COORD_BITS)) u_max_min (
      .clk_i, .en_i(en), .x_i(a_max[d]), .y_i(b_min[d]), .tol_i(tol_q),
      .gt_xy_o(g_amax_bmin[d]), .gt_yx_o(g_bmin_amax[d])
    );
  end

  // stage 3: per-axis relations, then reduce over axes
  logic [DIMS-1:0] ax_int, ax_win_ab, ax_win_ba, ax_ins_ab, ax_ins_ba;
  logic [DIMS-1:0] ax_cov_ab, ax_cov_ba, ax_ovl, ax_eq;
  logic            p_int, p_win_ab, p_win_ba, p_ins_ab, p_ins_ba;
  logic            p_cov_ab, p_cov_ba, p_ovl, p_eq;
  logic            holds_d, bad_d;

  always_comb begin
    logic eq_min, eq_max;
    for (int d = 0; d < DIMS; d++) begin
      eq_min        = !g_ab_min[d] && !g_ba_min[d];
      eq_max        = !g_ab_max[d] && !g_ba_max[d];
      ax_int[d]     = !g_bmin_amax[d] && !g_amin_bmax[d];
      ax_win_ab[d]  = !g_ba_min[d] && !g_ab_max[d];
      ax_win_ba[d]  = !g_ab_min[d] && !g_ba_max[d];
      ax_ins_ab[d]  = g_ab_min[d] && g_ba_max[d];
      ax_ins_ba[d]  = g_ba_min[d] && g_ab_max[d];
      ax_cov_ab[d]  = ax_win_ab[d] && (eq_min || eq_max);
      ax_cov_ba[d]  = ax_win_ba[d] && (eq_min || eq_max);
      ax_ovl[d]     = g_bmax_amin[d] && g_amax_bmin[d];
      ax_eq[d]      = eq_min && eq_max;
    end
  end

  assign p_int    = &ax_int;
  assign p_win_ab = &ax_win_ab;
  assign p_win_ba = &ax_win_ba;
  assign p_ins_ab = &ax_ins_ab;
  assign p_ins_ba = &ax_ins_ba;
  assign p_cov_ab = &ax_cov_ab;
  assign p_cov_ba = &ax_cov_ba;
  assign p_eq     = &ax_eq;
  // strict interval overlap, neither box inside or covered by the other
  assign p_ovl    = (&ax_ovl) && !p_ins_ab && !p_ins_ba && !p_cov_ab && !p_cov_ba;

  // predicate select
  always_comb begin
    holds_d = 1'b0;
    bad_d   = 1'b0;
    unique case (code2_q)
      btp_pkg::PRED_INTERSECTS:   holds_d = p_int;
      btp_pkg::PRED_DISJOINT:     holds_d = !p_int;
      btp_pkg::PRED_OVERLAP:      holds_d = p_ovl;
      btp_pkg::PRED_MEET:         holds_d = p_int && !p_ovl;
      btp_pkg::PRED_INSIDE:       holds_d = p_ins_ab;
      btp_pkg::PRED_CONTAINS:     holds_d = p_ins_ba;
      btp_pkg::PRED_COVERED_BY:   holds_d = p_cov_ab;
      btp_pkg::PRED_COVERS:       holds_d = p_cov_ba;
      btp_pkg::PRED_EQUAL:        holds_d = p_eq;
      btp_pkg::PRED_WITHIN:       holds_d = p_win_ab;
      btp_pkg::PRED_CONTAINS_COV: holds_d = p_win_ba;
      default: begin
        holds_d = 1'b0;
        bad_d   = 1'b1;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (en3) begin
      holds_q <= holds_d;
      bad_q   <= bad_d;
    end
  end

  assign out_valid_o = v3_q;
  assign holds_o     = holds_q;
  assign bad_code_o  = bad_q;

endmodule

@@ rtl/core/btp_checker.sv @@
// Port-level checks for the box topology predicate unit, bound to its top.
// Depends on box_topology_predicate_unit_macros.svh.
`include "box_topology_predicate_unit_macros.svh"

module btp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic holds_o,
  input logic bad_code_o
);

  // nothing comes out while reset is held
  `BTP_ASSERT_RST(a_reset_quiet, !rst_ni |-> !out_valid_o, "output valid during reset")

  // an undefined code never reports a true predicate
  `BTP_ASSERT(a_bad_not_holds, out_valid_o && bad_code_o |-> !holds_o, "bad code with holds set")

  // input backs up only when the output is full and stalled
  `BTP_ASSERT(a_stall_cause, in_stall_o |-> out_valid_o && out_stall_i, "input stalled without cause")

  // a stalled result word stays put
  `BTP_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(holds_o) && $stable(bad_code_o), "stalled result changed")

  // a word accepted while the output is not stalled reaches the output
  `BTP_ASSERT(a_latency, in_valid_i && !in_stall_o ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o, "result word missing")

endmodule

bind box_topology_predicate_unit btp_checker u_btp_checker (.*);
